// ===== sv/dcli_pkg.sv =====
// Shared types, constants and codes of the drag curve linear interpolator.
`timescale 1ns / 1ps

package dcli_pkg;

   localparam int MAX_POINTS = 128;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int COUNT_W    = $clog2(MAX_POINTS + 1);
   localparam int DIV_STEPS  = 32;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   localparam logic CSR_POINT_COUNT         = 1'b0;
   localparam logic CSR_DEFAULT_COEFFICIENT = 1'b1;

   typedef enum logic [1:0] {
      STATUS_INTERPOLATED = 2'd0,
      STATUS_CLAMPED_LOW  = 2'd1,
      STATUS_CLAMPED_HIGH = 2'd2,
      STATUS_EMPTY        = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIRST,
      S_LAST,
      S_SCAN,
      S_MUL,
      S_DIV_START,
      S_DIV,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic [15:0] mach;
      logic [15:0] coefficient;
   } entry_type;

   typedef struct packed {
      logic        done;
      logic [15:0] quotient;
      logic        rem_nonzero;
   } div_result_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] coefficient;
      status_type  status;
   } result_type;

endpackage

// ===== sv/dcli_divider.sv =====
// Restoring divider, one quotient bit per cycle, 32-bit numerator by 16-bit divisor.
`timescale 1ns / 1ps

module dcli_divider
   import dcli_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [31:0]    numerator,
   input  logic [15:0]    divisor,
   output div_result_type result
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [15:0]          rem_ff, rem_in;
   logic [31:0]          quo_ff, quo_in;
   logic [15:0]          divisor_ff, divisor_in;
   logic [16:0]          trial;
   logic                 fits;

   always_comb begin
      trial      = {rem_ff, quo_ff[31]};
      fits       = trial >= {1'b0, divisor_ff};
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         rem_in     = '0;
         quo_in     = numerator;
         divisor_in = divisor;
      end else if (busy_ff) begin
         // The remainder stays below the divisor, so its low 16 bits carry it.
         rem_in   = fits ? 16'(trial - {1'b0, divisor_ff}) : trial[15:0];
         quo_in   = {quo_ff[30:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff   <= count_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign result.done        = done_ff;
   assign result.quotient    = quo_ff[15:0];
   assign result.rem_nonzero = |rem_ff;

endmodule

// ===== sv/dcli_engine.sv =====
// Point table memory, configuration registers and the search and interpolation sequencer.
`timescale 1ns / 1ps

module dcli_engine
   import dcli_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [6:0]  req_point_index,
   input  logic [15:0] req_mach,
   input  logic [15:0] req_coefficient_in,
   input  logic        slot_ready,
   output result_type  result
);

   entry_type         mem [MAX_POINTS];
   entry_type         rd_data_ff;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;

   logic [7:0]        point_count_ff;
   logic [15:0]       default_coefficient_ff;
   logic [COUNT_W-1:0] count;

   state_type         state_ff, state_in;
   logic [15:0]       query_mach_ff, query_mach_in;
   entry_type         lo_ff, lo_in;
   entry_type         hi_ff, hi_in;
   logic [IDX_W-1:0]  scan_addr_ff, scan_addr_in;
   logic [31:0]       num_ff, num_in;
   logic [15:0]       dm_ff, dm_in;
   logic              desc_ff, desc_in;
   logic [15:0]       res_coef_ff, res_coef_in;
   status_type        res_status_ff, res_status_in;

   logic              div_start;
   div_result_type    div_result;
   logic              accept;
   logic [15:0]       diff;
   logic [15:0]       dx;
   logic [16:0]       sum;

   dcli_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numerator (num_ff),
      .divisor   (dm_ff),
      .result    (div_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff         <= '0;
         default_coefficient_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_POINT_COUNT:         point_count_ff         <= csr_data[7:0];
            CSR_DEFAULT_COEFFICIENT: default_coefficient_ff <= csr_data;
            default:                 ;
         endcase
      end
   end

   // Counts beyond the table depth use the whole table.
   assign count = (32'(point_count_ff) > MAX_POINTS) ? COUNT_W'(MAX_POINTS)
                                                     : COUNT_W'(point_count_ff);

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign wr_en     = accept && (req_action == ACTION_WRITE)
                      && (32'(req_point_index) < MAX_POINTS);
   assign wr_addr   = IDX_W'(req_point_index);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= '{mach: req_mach, coefficient: req_coefficient_in};
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in      = state_ff;
      query_mach_in = query_mach_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      scan_addr_in  = scan_addr_ff;
      num_in        = num_ff;
      dm_in         = dm_ff;
      desc_in       = desc_ff;
      res_coef_in   = res_coef_ff;
      res_status_in = res_status_ff;
      rd_addr       = '0;
      div_start     = 1'b0;
      diff          = desc_ff ? (lo_ff.coefficient - hi_ff.coefficient)
                              : (hi_ff.coefficient - lo_ff.coefficient);
      dx            = query_mach_ff - lo_ff.mach;
      sum           = {1'b0, lo_ff.coefficient} + {1'b0, div_result.quotient};

      case (state_ff)
         S_IDLE: begin
            if (accept && (req_action == ACTION_QUERY)) begin
               query_mach_in = req_mach;
               if (count == '0) begin
                  res_coef_in   = default_coefficient_ff;
                  res_status_in = STATUS_EMPTY;
                  state_in      = S_EMIT;
               end else begin
                  state_in = S_FIRST;
               end
            end
         end
         S_FIRST: begin
            lo_in = rd_data_ff;
            if (query_mach_ff <= rd_data_ff.mach) begin
               res_coef_in   = rd_data_ff.coefficient;
               res_status_in = STATUS_CLAMPED_LOW;
               state_in      = S_EMIT;
            end else begin
               rd_addr  = IDX_W'(count - 1'b1);
               state_in = S_LAST;
            end
         end
         S_LAST: begin
            if (query_mach_ff >= rd_data_ff.mach) begin
               res_coef_in   = rd_data_ff.coefficient;
               res_status_in = STATUS_CLAMPED_HIGH;
               state_in      = S_EMIT;
            end else begin
               rd_addr      = IDX_W'(1);
               scan_addr_in = IDX_W'(1);
               state_in     = S_SCAN;
            end
         end
         S_SCAN: begin
            // The last point lies above the query, so the scan stops inside the table.
            if (rd_data_ff.mach < query_mach_ff) begin
               lo_in        = rd_data_ff;
               scan_addr_in = scan_addr_ff + 1'b1;
               rd_addr      = scan_addr_ff + 1'b1;
            end else begin
               hi_in    = rd_data_ff;
               desc_in  = rd_data_ff.coefficient < lo_ff.coefficient;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            num_in   = 32'(diff) * 32'(dx);
            dm_in    = hi_ff.mach - lo_ff.mach;
            state_in = S_DIV_START;
         end
         S_DIV_START: begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_result.done) begin
               // A falling segment rounds the step up so the result still rounds down.
               res_coef_in   = desc_ff ? (lo_ff.coefficient - div_result.quotient
                                          - 16'(div_result.rem_nonzero))
                                       : sum[15:0];
               res_status_in = STATUS_INTERPOLATED;
               state_in      = S_EMIT;
            end
         end
         S_EMIT: begin
            if (slot_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      query_mach_ff <= query_mach_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      scan_addr_ff  <= scan_addr_in;
      num_ff        <= num_in;
      dm_ff         <= dm_in;
      desc_ff       <= desc_in;
      res_coef_ff   <= res_coef_in;
      res_status_ff <= res_status_in;
   end

   assign result.valid       = (state_ff == S_EMIT);
   assign result.coefficient = res_coef_ff;
   assign result.status      = res_status_ff;

endmodule

// ===== sv/drag_curve_linear_interpolator.sv =====
// Top level of the drag curve linear interpolator with its response register.
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    action, point_index, mach, coefficient_in
// rsp_      out        rsp_valid/stall    coefficient, status
// csr_      in         csr_write          csr_index, csr_data
//
// A point write does not hold the request port. A query holds it while it runs;
// an empty table ends soonest, then a low clamp, then a high clamp, and longest an
// interpolation, which scans points through the single read port of the table
// memory and then waits for the 32-step divider.
// Reset clears the control state and the configuration registers; the table is not cleared.
// A stalled response waits in its register while the next request is taken.

module drag_curve_linear_interpolator
   import dcli_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [6:0]  req_point_index,
   input  logic [15:0] req_mach,
   input  logic [15:0] req_coefficient_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_coefficient,
   output logic [1:0]  rsp_status
);

   result_type  result;
   logic        slot_ready;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_coefficient_ff, rsp_coefficient_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   // The response register is free when empty or when its response leaves this cycle.
   assign slot_ready = !rsp_valid_ff || !rsp_stall;

   dcli_engine u_engine (
      .clock              (clock),
      .reset              (reset),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_point_index    (req_point_index),
      .req_mach           (req_mach),
      .req_coefficient_in (req_coefficient_in),
      .slot_ready         (slot_ready),
      .result             (result)
   );

   always_comb begin
      rsp_valid_in       = rsp_valid_ff;
      rsp_coefficient_in = rsp_coefficient_ff;
      rsp_status_in      = rsp_status_ff;
      if (slot_ready) begin
         rsp_valid_in = result.valid;
         if (result.valid) begin
            rsp_coefficient_in = result.coefficient;
            rsp_status_in      = result.status;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_coefficient_ff <= rsp_coefficient_in;
      rsp_status_ff      <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_coefficient = rsp_coefficient_ff;
   assign rsp_status      = rsp_status_ff;

   // An accepted query always moves the sequencer out of idle, so the request port stalls.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_action == ACTION_QUERY) |=> req_stall)
      else $error("query accepted without holding the request port");

   // A point write finishes in the cycle it is taken.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_action == ACTION_WRITE) |=> !req_stall)
      else $error("point write held the request port");

   // A finished result offered to a free response register shows up next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (result.valid && slot_ready) |=> rsp_valid)
      else $error("finished result lost before the response register");

   // The sequencer is never released while a result still waits for the register.
   assert property (@(posedge clock) disable iff (reset)
      (result.valid && !slot_ready) |=> req_stall)
      else $error("request port released with a result pending");

endmodule

// ===== verif/drag_curve_checker.sv =====
// Checker that predicts and compares the responses of the drag curve interpolator.
`timescale 1ns / 1ps

module drag_curve_checker
   import dcli_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_data,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_action,
   input  logic [6:0]  req_point_index,
   input  logic [15:0] req_mach,
   input  logic [15:0] req_coefficient_in,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [15:0] rsp_coefficient,
   input  logic [1:0]  rsp_status,
   output int          failure_count,
   output int          pending_count
);

   typedef struct {
      logic [15:0] coefficient;
      status_type  status;
   } drag_lookup_type;

   logic [15:0]     curve_mach [MAX_POINTS];
   logic [15:0]     curve_cd   [MAX_POINTS];
   logic [7:0]      loaded_points;
   logic [15:0]     empty_cd;
   drag_lookup_type drag_lookup_q[$];
   int              mismatches = 0;

   function automatic drag_lookup_type predict_drag(input logic [15:0] query);
      drag_lookup_type res;
      int              n;
      int              i;
      longint          rise;
      longint          run;
      longint          step;
      n = (loaded_points > MAX_POINTS) ? MAX_POINTS : int'(loaded_points);
      if (n == 0) begin
         res.coefficient = empty_cd;
         res.status      = STATUS_EMPTY;
      end else if (query <= curve_mach[0]) begin
         res.coefficient = curve_cd[0];
         res.status      = STATUS_CLAMPED_LOW;
      end else if (query >= curve_mach[n - 1]) begin
         res.coefficient = curve_cd[n - 1];
         res.status      = STATUS_CLAMPED_HIGH;
      end else begin
         i = 0;
         while (i + 1 < n && curve_mach[i + 1] < query)
            i++;
         rise = (longint'(curve_cd[i + 1]) - longint'(curve_cd[i]))
                * (longint'(query) - longint'(curve_mach[i]));
         run  = longint'(curve_mach[i + 1]) - longint'(curve_mach[i]);
         step = rise / run;
         // Division truncates toward zero, but a falling segment has to round down.
         if (rise < 0 && step * run != rise)
            step = step - 1;
         res.coefficient = 16'(longint'(curve_cd[i]) + step);
         res.status      = STATUS_INTERPOLATED;
      end
      return res;
   endfunction

   always @(posedge clock) begin : watch
      drag_lookup_type want;
      if (reset) begin
         loaded_points = '0;
         empty_cd      = '0;
         drag_lookup_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (drag_lookup_q.size() == 0) begin
               $error("response with no query outstanding: coefficient %h, status %0d",
                      rsp_coefficient, rsp_status);
               mismatches++;
            end else begin
               want = drag_lookup_q.pop_front();
               if (rsp_coefficient !== want.coefficient) begin
                  $error("coefficient: expected %h, actual %h",
                         want.coefficient, rsp_coefficient);
                  mismatches++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  mismatches++;
               end
            end
         end
         if (csr_write) begin
            if (csr_index == CSR_POINT_COUNT)
               loaded_points = csr_data[7:0];
            else if (csr_index == CSR_DEFAULT_COEFFICIENT)
               empty_cd = csr_data;
         end
         if (req_valid && !req_stall) begin
            if (req_action == ACTION_WRITE) begin
               curve_mach[req_point_index] = req_mach;
               curve_cd[req_point_index]   = req_coefficient_in;
            end else begin
               drag_lookup_q.push_back(predict_drag(req_mach));
            end
         end
      end
      failure_count <= mismatches;
      pending_count <= drag_lookup_q.size();
   end

endmodule

// ===== verif/tb.sv =====
// Testbench top that drives requests and register writes into the drag curve interpolator.
`timescale 1ns / 1ps

module tb;
   import dcli_pkg::*;

   // The receiver holds off this long once, so that a finished response waits in
   // its register, the next query completes behind it and the request port stalls.
   localparam int HOLD_OFF_CYCLES = 500;
   // A point write is stored at the clock edge that takes it, so this is ample margin
   // before a register write.
   localparam int SETTLE_CYCLES   = 16;
   // This outlasts the longest query (full table scan plus the divider).
   localparam int DRAIN_CYCLES    = 200;
   localparam int RANDOM_ITEMS    = 1600;

   logic        clock              = 1'b0;
   logic        reset              = 1'b1;
   logic        csr_write          = 1'b0;
   logic        csr_index          = CSR_POINT_COUNT;
   logic [15:0] csr_data           = '0;
   logic        req_valid          = 1'b0;
   logic        req_stall;
   logic        req_action         = ACTION_QUERY;
   logic [6:0]  req_point_index    = '0;
   logic [15:0] req_mach           = '0;
   logic [15:0] req_coefficient_in = '0;
   logic        rsp_valid;
   logic        rsp_stall          = 1'b0;
   logic [15:0] rsp_coefficient;
   logic [1:0]  rsp_status;
   int          failures;
   int          pending;

   // Mach values last written to each entry; used only to aim queries at the points.
   logic [15:0] shadow_mach [MAX_POINTS];
   // While calm is set, neither side inserts random idle cycles.
   bit          calm         = 1'b0;
   int          hold_asked   = 0;
   int          random_items = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   drag_curve_linear_interpolator u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_point_index    (req_point_index),
      .req_mach           (req_mach),
      .req_coefficient_in (req_coefficient_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_coefficient    (rsp_coefficient),
      .rsp_status         (rsp_status)
   );

   drag_curve_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_point_index    (req_point_index),
      .req_mach           (req_mach),
      .req_coefficient_in (req_coefficient_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_coefficient    (rsp_coefficient),
      .rsp_status         (rsp_status),
      .failure_count      (failures),
      .pending_count      (pending)
   );

   // Response side. Each cycle it either serves a requested long hold-off, counted
   // here, or, unless calm is set, stalls at random with a chance of about one in nine.
   initial begin : response_side
      int hold_left;
      int hold_served;
      hold_left   = 0;
      hold_served = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_served != hold_asked) begin
            hold_served++;
            hold_left = HOLD_OFF_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 11);
         end
      end
   end

   task automatic write_csr(input logic index, input logic [15:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // Offers one request and returns at the clock edge that takes it. A random gap
   // may come first; with drain set, the sender also waits until every outstanding
   // query has been answered. Valid stays high from one request to the next when
   // there is no gap, so it is never lowered and raised in the same step.
   task automatic send_request(input logic action, input logic [6:0] index,
                               input logic [15:0] mach, input logic [15:0] cd,
                               input bit drain);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(99) < 11)
         gap = $urandom_range(1, ($urandom_range(3) == 0) ? 60 : 4);
      if (drain && gap == 0)
         gap = 1;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         while (drain && pending != 0) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_action         <= action;
      req_point_index    <= index;
      req_mach           <= mach;
      req_coefficient_in <= cd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (action == ACTION_WRITE)
         shadow_mach[index] = mach;
      random_items++;
   endtask

   // Waits until the block is idle: no request offered, no query outstanding,
   // and SETTLE_CYCLES more for a trailing point write.
   task automatic settle();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Coefficient values lean toward both extremes.
   function automatic logic [15:0] rand_cd();
      case ($urandom_range(7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Query Mach: on or one step beside a loaded point, where the clamp and bracket
   // decisions flip, as often as anywhere in range, otherwise at either end.
   function automatic logic [15:0] aim_mach(input int n);
      int pick;
      pick = $urandom_range(9);
      if (n == 0 || pick < 4)
         return 16'($urandom);
      if (pick == 8)
         return 16'h0000;
      if (pick == 9)
         return 16'hFFFF;
      return shadow_mach[$urandom_range(n - 1)] + 16'($urandom_range(2)) - 16'd1;
   endfunction

   // Loads entries 0 to n-1 in ascending Mach order. Steps of zero give repeated
   // Mach values, and the first and last point sometimes sit at the range ends.
   task automatic load_sorted(input int n);
      int step_max;
      int m;
      step_max = 65535 / n;
      m = ($urandom_range(3) == 0) ? 0 : $urandom_range(step_max);
      for (int i = 0; i < n; i++) begin
         if (i == n - 1 && $urandom_range(3) == 0)
            m = 65535;
         send_request(ACTION_WRITE, 7'(i), 16'(m), rand_cd(), 1'b0);
         m += $urandom_range(step_max);
      end
   endtask

   // One random phase: registers are set while the block is idle, then a table is
   // loaded and queried. Most phases use a sorted table with a few points; some use
   // all 128 points, some scramble the table and some run with it empty. Stray
   // point writes are mixed in with the queries. The first phase fills the whole
   // table so that later phases never read an entry that was never written.
   task automatic run_phase(input int phase);
      int kind;
      int n;
      int count_value;
      kind = (phase == 0) ? 0 : $urandom_range(9);
      if (kind <= 5) begin
         if (phase == 0 || $urandom_range(7) == 0)
            n = MAX_POINTS;
         else
            n = ($urandom_range(5) == 0) ? 1 : $urandom_range(2, 12);
      end else if (kind <= 7) begin
         n = ($urandom_range(7) == 0) ? MAX_POINTS : $urandom_range(1, 16);
      end else begin
         n = 0;
      end
      // A count above the table size acts as a full table.
      count_value = n;
      if (n == MAX_POINTS && $urandom_range(1) == 1)
         count_value = $urandom_range(MAX_POINTS + 1, 255);
      calm = (phase >= 5 && phase < 10);
      // Only the low byte of the write data reaches the point count.
      write_csr(CSR_POINT_COUNT, {8'($urandom), 8'(count_value)});
      write_csr(CSR_DEFAULT_COEFFICIENT, rand_cd());
      if (kind <= 5) begin
         load_sorted(n);
      end else if (kind <= 7) begin
         repeat ($urandom_range(1, n))
            send_request(ACTION_WRITE, 7'($urandom_range(n - 1)), 16'($urandom),
                         rand_cd(), 1'b0);
      end
      if (phase == 2)
         hold_asked <= hold_asked + 1;
      repeat ($urandom_range(8, 40)) begin
         if ($urandom_range(9) == 0)
            send_request(ACTION_WRITE, 7'($urandom), 16'($urandom), rand_cd(), 1'b0);
         else
            send_request(ACTION_QUERY, 7'($urandom), aim_mach(n), 16'($urandom),
                         $urandom_range(39) == 0);
      end
      settle();
   endtask

   initial begin : stimulus
      int phase;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty table: every query returns the default with the empty status.
      // Points are loaded meanwhile, including the highest index.
      write_csr(CSR_POINT_COUNT, 16'd0);
      write_csr(CSR_DEFAULT_COEFFICIENT, 16'hFFFF);
      send_request(ACTION_QUERY, 7'h7F, 16'h0000, 16'hFFFF, 1'b0);
      send_request(ACTION_QUERY, 7'h00, 16'hFFFF, 16'h0000, 1'b0);
      send_request(ACTION_WRITE, 7'd0, 16'h1000, 16'h8000, 1'b0);
      send_request(ACTION_WRITE, 7'd1, 16'h2000, 16'h4000, 1'b0);
      send_request(ACTION_WRITE, 7'd2, 16'h3000, 16'hFFFF, 1'b0);
      send_request(ACTION_WRITE, 7'd3, 16'hFFFF, 16'h0000, 1'b0);
      send_request(ACTION_WRITE, 7'h7F, 16'hFFFF, 16'hFFFF, 1'b0);
      settle();

      // A single point: at or below it clamps low, above it clamps high.
      write_csr(CSR_POINT_COUNT, 16'd1);
      send_request(ACTION_QUERY, 7'd0, 16'h0FFF, 16'h0000, 1'b0);
      send_request(ACTION_QUERY, 7'd0, 16'h1000, 16'h0000, 1'b0);
      send_request(ACTION_QUERY, 7'd0, 16'h1001, 16'h0000, 1'b0);
      settle();

      // Four points: a query equal to the first point still clamps low; rising and
      // falling segments, an exact hit on an inner point, and the top of the range.
      write_csr(CSR_POINT_COUNT, 16'd4);
      write_csr(CSR_DEFAULT_COEFFICIENT, 16'h0000);
      send_request(ACTION_QUERY, 7'd0, 16'h1000, 16'h0000, 1'b0);
      send_request(ACTION_QUERY, 7'd0, 16'h1800, 16'h0000, 1'b0);
      send_request(ACTION_QUERY, 7'd0, 16'h2000, 16'h0000, 1'b0);
      send_request(ACTION_QUERY, 7'd0, 16'h2001, 16'h0000, 1'b0);
      send_request(ACTION_QUERY, 7'd0, 16'h3001, 16'h0000, 1'b0);
      send_request(ACTION_QUERY, 7'd0, 16'hFFFE, 16'h0000, 1'b0);
      send_request(ACTION_QUERY, 7'd0, 16'hFFFF, 16'h0000, 1'b0);

      // Unsorted table: the second point drops below the first.
      send_request(ACTION_WRITE, 7'd1, 16'h0800, 16'h1234, 1'b0);
      send_request(ACTION_QUERY, 7'd0, 16'h1800, 16'h0000, 1'b0);
      send_request(ACTION_QUERY, 7'd0, 16'h0C00, 16'h0000, 1'b0);
      send_request(ACTION_QUERY, 7'd0, 16'h2800, 16'h0000, 1'b0);
      settle();

      random_items = 0;
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         run_phase(phase);
         phase++;
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && pending == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Several times the slowest legal run: every request a full-table query.
   initial begin : watchdog
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== files.f =====
sv/dcli_pkg.sv
sv/dcli_divider.sv
sv/dcli_engine.sv
sv/drag_curve_linear_interpolator.sv
verif/drag_curve_checker.sv
verif/tb.sv
